### src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define LRCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define LRCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/lrcs_pkg.sv
`timescale 1ns / 1ps

package lrcs_pkg;

    localparam int HEADER_BYTES_DEF = 16;
    localparam int OFFSET_WIDTH_DEF = 48;

    localparam int LEN_W     = 32;
    localparam int CRC_W     = 32;
    localparam int SEQ_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int RSP_OFF_W = 48;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

    // Request type codes; the unused code is ignored.
    localparam logic [1:0] REQ_HEADER  = 2'd0;
    localparam logic [1:0] REQ_PAYLOAD = 2'd1;
    localparam logic [1:0] REQ_END     = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_STOPPED = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [LEN_W-1:0]  body_len;
        logic [CRC_W-1:0]  stored_crc;
        logic [SEQ_W-1:0]  rec_seq;
        logic [BYTE_W-1:0] payload_byte;
    } t_req_item;

    typedef struct packed {
        logic [SEQ_W-1:0]     resume_seq;
        logic [RSP_OFF_W-1:0] good_end_offset;
        logic                 record_accepted;
        logic                 scan_stopped;
        logic                 scan_done;
    } t_rsp_item;

endpackage

### src/lrcs_crc_byte.sv
`timescale 1ns / 1ps

// One byte of reflected CRC-32, bitwise over eight steps.
module lrcs_crc_byte (
    input  logic [lrcs_pkg::CRC_W-1:0]  i_crc,
    input  logic [lrcs_pkg::BYTE_W-1:0] i_byte,
    output logic [lrcs_pkg::CRC_W-1:0]  o_crc
);
    import lrcs_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ CRC_W'(i_byte);
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

### src/lrcs_scan_core.sv
`timescale 1ns / 1ps

// Scan state and result register. One request is processed per advance.
module lrcs_scan_core #(
    parameter int HEADER_BYTES = lrcs_pkg::HEADER_BYTES_DEF,
    parameter int OFFSET_WIDTH = lrcs_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  lrcs_pkg::t_req_item i_item,
    output logic                o_advance,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output lrcs_pkg::t_rsp_item o_rsp
);
    import lrcs_pkg::*;

    localparam int SumW = ((OFFSET_WIDTH > LEN_W) ? OFFSET_WIDTH : LEN_W) + 2;

    t_phase                  r_phase, n_phase;
    logic [CRC_W-1:0]        r_running_crc, n_running_crc;
    logic [LEN_W-1:0]        r_bytes_left, n_bytes_left;
    logic [CRC_W-1:0]        r_expected_crc, n_expected_crc;
    logic [SEQ_W-1:0]        r_pending_seq, n_pending_seq;
    logic [OFFSET_WIDTH-1:0] r_pending_off, n_pending_off;
    logic [SEQ_W-1:0]        r_resume_seq, n_resume_seq;
    logic [OFFSET_WIDTH-1:0] r_scan_offset, n_scan_offset;
    logic                    r_rsp_valid;
    t_rsp_item               r_rsp, n_rsp;

    logic [CRC_W-1:0] crc_upd;
    logic [SumW-1:0]  end_sum;
    logic             off_ovf;
    logic [63:0]      off_ext;
    logic             take;

    lrcs_crc_byte u_crc (
        .i_crc  (r_running_crc),
        .i_byte (i_item.payload_byte),
        .o_crc  (crc_upd)
    );

    assign o_advance = !r_rsp_valid || i_rsp_ready;
    assign take      = i_item_valid && o_advance;

    // Offset past the record if this header is taken; overflow if it spills out.
    assign end_sum = SumW'(r_scan_offset) + SumW'(HEADER_BYTES) + SumW'(i_item.body_len);
    assign off_ovf = |end_sum[SumW-1:OFFSET_WIDTH];

    always_comb begin
        n_phase        = r_phase;
        n_running_crc  = r_running_crc;
        n_bytes_left   = r_bytes_left;
        n_expected_crc = r_expected_crc;
        n_pending_seq  = r_pending_seq;
        n_pending_off  = r_pending_off;
        n_resume_seq   = r_resume_seq;
        n_scan_offset  = r_scan_offset;
        n_rsp          = '0;
        off_ext        = '0;

        unique case (i_item.req_type)
            REQ_HEADER: begin
                if (r_phase == PH_HEADER) begin
                    if (off_ovf) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_bytes_left   = i_item.body_len;
                        n_expected_crc = i_item.stored_crc;
                        n_pending_seq  = i_item.rec_seq;
                        n_pending_off  = end_sum[OFFSET_WIDTH-1:0];
                        n_running_crc  = CRC_INIT;
                        if (i_item.body_len == '0) begin
                            // Empty payload: CRC of no bytes is zero.
                            if (i_item.stored_crc == '0) begin
                                n_resume_seq          = i_item.rec_seq + SEQ_W'(1);
                                n_scan_offset         = end_sum[OFFSET_WIDTH-1:0];
                                n_rsp.record_accepted = 1'b1;
                            end else begin
                                n_phase = PH_STOPPED;
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end else if (r_phase == PH_PAYLOAD) begin
                    n_phase = PH_STOPPED;
                end
            end
            REQ_PAYLOAD: begin
                if (r_phase == PH_PAYLOAD) begin
                    n_running_crc = crc_upd;
                    n_bytes_left  = r_bytes_left - LEN_W'(1);
                    if (r_bytes_left == LEN_W'(1)) begin
                        if ((crc_upd ^ CRC_XOUT) == r_expected_crc) begin
                            n_resume_seq          = r_pending_seq + SEQ_W'(1);
                            n_scan_offset         = r_pending_off;
                            n_phase               = PH_HEADER;
                            n_rsp.record_accepted = 1'b1;
                        end else begin
                            n_phase = PH_STOPPED;
                        end
                    end
                end else if (r_phase == PH_HEADER) begin
                    n_phase = PH_STOPPED;
                end
            end
            REQ_END: begin
                n_rsp.scan_done = 1'b1;
            end
            default: begin
            end
        endcase

        off_ext               = 64'(n_scan_offset);
        n_rsp.resume_seq      = n_resume_seq;
        n_rsp.good_end_offset = off_ext[RSP_OFF_W-1:0];
        n_rsp.scan_stopped    = (n_phase == PH_STOPPED);

        // End of data re-arms the scan after reporting.
        if (n_rsp.scan_done) begin
            n_phase        = PH_HEADER;
            n_running_crc  = CRC_INIT;
            n_bytes_left   = '0;
            n_expected_crc = '0;
            n_pending_seq  = '0;
            n_pending_off  = '0;
            n_resume_seq   = '0;
            n_scan_offset  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_running_crc  <= CRC_INIT;
            r_bytes_left   <= '0;
            r_expected_crc <= '0;
            r_pending_seq  <= '0;
            r_pending_off  <= '0;
            r_resume_seq   <= '0;
            r_scan_offset  <= '0;
            r_rsp_valid    <= 1'b0;
        end else begin
            if (take) begin
                r_phase        <= n_phase;
                r_running_crc  <= n_running_crc;
                r_bytes_left   <= n_bytes_left;
                r_expected_crc <= n_expected_crc;
                r_pending_seq  <= n_pending_seq;
                r_pending_off  <= n_pending_off;
                r_resume_seq   <= n_resume_seq;
                r_scan_offset  <= n_scan_offset;
            end
            if (o_advance) begin
                r_rsp_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### src/log_record_crc_scanner_top.sv
`timescale 1ns / 1ps
// Path: input register, then the core's CRC step, then the result register.
// Throughput: one request per cycle while the result channel is not stalled;
//   the byte-wide CRC step is combinational between the two registers.
// Reset: synchronous, active low; clears both valid flags and all scan
//   state (phase awaiting header, CRC all ones, counters and offsets zero).

module log_record_crc_scanner_top #(
    parameter int HEADER_BYTES = lrcs_pkg::HEADER_BYTES_DEF,
    parameter int OFFSET_WIDTH = lrcs_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  lrcs_pkg::t_req_item i_req,
    // result channel
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output lrcs_pkg::t_rsp_item o_rsp
);
    import lrcs_pkg::*;

    // Input register: holds one request until the core consumes it.
    logic      r_in_valid, n_in_valid;
    t_req_item r_in;
    logic      core_advance;
    logic      in_take;
    logic      req_fire;

    // The core consumes the held request whenever its result slot frees up,
    // so a new request can land in the same cycle.
    assign in_take     = r_in_valid && core_advance;
    assign o_req_ready = !r_in_valid || core_advance;
    assign req_fire    = i_req_valid && o_req_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (req_fire) begin
            n_in_valid = 1'b1;
        end else if (in_take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_in <= i_req;
        end
    end

    // Scan state, CRC update and the result register.
    lrcs_scan_core #(
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_advance    (core_advance),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_rsp        (o_rsp)
    );

endmodule

### src/lrcs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_req_ready,
    input logic                o_rsp_valid,
    input logic                i_rsp_ready,
    input lrcs_pkg::t_rsp_item o_rsp
);
    import lrcs_pkg::*;

    // stalled result holds
    `LRCS_ASSERT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "result changed while stalled")

    // nothing comes out of reset
    `LRCS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_rsp_valid, "result valid right after reset")

    // empty result slot means room for a request
    `LRCS_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_rsp_valid |-> o_req_ready, "request stalled with empty output")

    `LRCS_ASSERT(a_acc_not_stopped, i_clk, i_rst_n, o_rsp_valid && o_rsp.record_accepted |-> !o_rsp.scan_stopped, "accepted record while stopped")

    `LRCS_ASSERT(a_done_not_acc, i_clk, i_rst_n, o_rsp_valid && o_rsp.scan_done |-> !o_rsp.record_accepted, "end request flagged a record")

endmodule

bind log_record_crc_scanner_top lrcs_checker u_lrcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
